// File: src/lrukv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Request codes, register map and the control structs shared by the cache
// top level and its entry table.
// ----------------------------------------------------------------------------
package lrukv_pkg;

    // Request kinds carried in s_tuser
    localparam logic [1:0] REQ_GET    = 2'd0;
    localparam logic [1:0] REQ_PUT    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // Fixed field widths
    localparam int OCC_BITS   = 5;
    localparam int CAP_BITS   = 5;
    localparam int PADDR_BITS = 3;

    // Register map: word index taken from paddr[PADDR_BITS-1:2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Command from the request register into the entry table
    typedef struct packed {
        logic       fire;
        logic [1:0] req_type;
    } lrukv_cmd_t;

    // Status flags of one result
    typedef struct packed {
        logic evicted;
        logic hit;
    } lrukv_flags_t;

endpackage

// File: src/lrukv_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache configuration registers
// APB-style slave holding the capacity limit; zero wait states.
// ----------------------------------------------------------------------------
module lrukv_cfg
    import lrukv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [CAP_BITS-1:0]   capacity_limit
);

    logic [CAP_BITS-1:0] cap_reg;
    logic                reg_index;
    logic                wr_en;

    assign reg_index = paddr[PADDR_BITS-1];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;

    // Capture the capacity limit on a completed write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (wr_en && (reg_index == REG_CAPACITY)) begin
            cap_reg <= pwdata[CAP_BITS-1:0];
        end
    end

    // Return the addressed register, zero elsewhere
    always_comb begin
        prdata = '0;
        if (reg_index == REG_CAPACITY) begin
            prdata = {{(32 - CAP_BITS){1'b0}}, cap_reg};
        end
    end

    assign capacity_limit = cap_reg;

endmodule

// File: src/lrukv_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache entry table
// Holds keys, values, valid bits and recency ranks. One request is looked up
// and applied per fire: parallel key compare, rank update and slot allocation.
// ----------------------------------------------------------------------------
module lrukv_table
    import lrukv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lrukv_cmd_t            cmd,
    input  logic [CAP_BITS-1:0]   capacity_limit,
    input  logic [KEY_BITS-1:0]   lookup_key,
    input  logic [VALUE_BITS-1:0] write_value,
    input  logic [VALUE_BITS-1:0] default_value,
    output lrukv_flags_t          flags,
    output logic [VALUE_BITS-1:0] read_value,
    output logic [KEY_BITS-1:0]   evicted_key,
    output logic [OCC_BITS-1:0]   occupancy
);

    localparam int RW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

    // Entry storage: one lane per slot
    logic [KEY_BITS-1:0]   key_reg   [ENTRIES];
    logic [VALUE_BITS-1:0] value_reg [ENTRIES];
    logic [RW-1:0]         rank_reg  [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;
    logic [CW-1:0]         count_reg;

    logic [KEY_BITS-1:0]   key_next   [ENTRIES];
    logic [VALUE_BITS-1:0] value_next [ENTRIES];
    logic [RW-1:0]         rank_next  [ENTRIES];
    logic [ENTRIES-1:0]    valid_next;
    logic [CW-1:0]         count_next;

    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    victim;
    logic [ENTRIES-1:0]    drop_mask;
    logic [ENTRIES-1:0]    avail;
    logic [ENTRIES-1:0]    free_oh;
    logic                  hit_any;
    logic [VALUE_BITS-1:0] hit_value;
    logic [RW-1:0]         hit_rank;
    logic [KEY_BITS-1:0]   victim_key;
    logic [CW-1:0]         count_m1;
    logic [RW-1:0]         last_rank;
    logic [CMPW-1:0]       cap_ext;
    logic [CMPW-1:0]       cap_eff;
    logic [CMPW-1:0]       count_ext;
    logic [CMPW-1:0]       occ_ext;
    logic                  evict;

    assign count_m1  = count_reg - CW'(1);
    assign last_rank = count_m1[RW-1:0];

    // Compare every lane against the key; the least recent holds the last rank
    always_comb begin
        match      = '0;
        victim     = '0;
        hit_value  = '0;
        hit_rank   = '0;
        victim_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = valid_reg[i] && (key_reg[i] == lookup_key);
            victim[i] = valid_reg[i] && (rank_reg[i] == last_rank);
            if (match[i]) begin
                hit_value = hit_value | value_reg[i];
                hit_rank  = hit_rank | rank_reg[i];
            end
            if (victim[i]) begin
                victim_key = victim_key | key_reg[i];
            end
        end
    end

    assign hit_any = |match;

    // Clamp the capacity to 1 .. ENTRIES
    assign cap_ext   = CMPW'(capacity_limit);
    assign count_ext = CMPW'(count_reg);
    always_comb begin
        cap_eff = cap_ext;
        if (cap_ext == '0) begin
            cap_eff = CMPW'(1);
        end else if (cap_ext > CMPW'(ENTRIES)) begin
            cap_eff = CMPW'(ENTRIES);
        end
    end

    // Evict on a new key once occupancy reaches the capacity limit; take the lowest free slot
    assign evict     = (cmd.req_type == REQ_PUT) && !hit_any && (count_ext >= cap_eff);
    assign drop_mask = evict ? victim : '0;
    assign avail     = ~(valid_reg & ~drop_mask);
    assign free_oh   = avail & (~avail + ENTRIES'(1));

    // Next state of every lane
    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            key_next[i]   = key_reg[i];
            value_next[i] = value_reg[i];
            rank_next[i]  = rank_reg[i];
        end
        case (cmd.req_type) inside
            REQ_GET, REQ_PUT: begin
                if (hit_any) begin
                    // Move the hit entry to the front, age the ones ahead of it
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (match[i]) begin
                            rank_next[i] = '0;
                            if (cmd.req_type == REQ_PUT) begin
                                value_next[i] = write_value;
                            end
                        end else if (valid_reg[i] && (rank_reg[i] < hit_rank)) begin
                            rank_next[i] = rank_reg[i] + RW'(1);
                        end
                    end
                end else if (cmd.req_type == REQ_PUT) begin
                    // Insert the new key at the front, age all others
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (free_oh[i]) begin
                            key_next[i]   = lookup_key;
                            value_next[i] = write_value;
                            rank_next[i]  = '0;
                        end else if (valid_reg[i] && !drop_mask[i]) begin
                            rank_next[i] = rank_reg[i] + RW'(1);
                        end
                    end
                    valid_next = (valid_reg & ~drop_mask) | free_oh;
                    if (!evict) begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            REQ_REMOVE: begin
                if (hit_any) begin
                    // Drop the entry, advance the ones behind it
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (valid_reg[i] && !match[i] && (rank_reg[i] > hit_rank)) begin
                            rank_next[i] = rank_reg[i] - RW'(1);
                        end
                    end
                    valid_next = valid_reg & ~match;
                    count_next = count_m1;
                end
            end
            REQ_CLEAR: begin
                valid_next = '0;
                count_next = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else if (cmd.fire) begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // Entry payload
    always_ff @(posedge aclk) begin
        if (cmd.fire) begin
            for (int i = 0; i < ENTRIES; i++) begin
                key_reg[i]   <= key_next[i];
                value_reg[i] <= value_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

    // Result of this request
    assign occ_ext       = CMPW'(count_next);
    assign occupancy     = occ_ext[OCC_BITS-1:0];
    assign flags.hit     = hit_any && (cmd.req_type != REQ_CLEAR);
    assign flags.evicted = evict;
    assign read_value    = ((cmd.req_type == REQ_GET) && hit_any) ? hit_value : default_value;
    assign evicted_key   = evict ? victim_key : '0;

endmodule

// File: src/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
//
// Requests enter on the s_ stream: s_tuser carries the request kind (get,
// put, remove, clear) and s_tdata the key, the value to write and the default
// value. Every request yields exactly one result on the m_ stream: m_tuser
// carries the hit and evicted flags, m_tdata the read value, evicted key and
// occupancy. Capacity is set through the APB port (register 0, byte address
// 0) and is to be changed by the user only while the cache is idle; the
// block itself does not enforce this. A transaction is held in a request
// register and, once the result register can take it, resolved against all
// entries in parallel; the result lands in an output register. One request
// is accepted every cycle while the receiver keeps up, as the compare and
// rank update are combinational. When the receiver stalls, the result holds
// in the output register, one more request waits in the request register,
// and s_tready then drops. Reset empties the table, clears both stream
// stages and sets the capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache
    import lrukv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int S_DATA_BITS = ((KEY_BITS + 2 * VALUE_BITS + 7) / 8) * 8,
    localparam int M_DATA_BITS = ((VALUE_BITS + KEY_BITS + OCC_BITS + 7) / 8) * 8
)(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_BITS-1:0]  paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // lookup_key, write_value, default_value
    input  logic [S_DATA_BITS-1:0] s_tdata,
    // req_type
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // read_value, evicted_key, occupancy
    output logic [M_DATA_BITS-1:0] m_tdata,
    // hit, evicted
    output logic [1:0]             m_tuser
);

    logic [CAP_BITS-1:0]   capacity_limit;

    // Request register
    logic                  in_valid_reg;
    logic [1:0]            in_type_reg;
    logic [KEY_BITS-1:0]   in_key_reg;
    logic [VALUE_BITS-1:0] in_wval_reg;
    logic [VALUE_BITS-1:0] in_dval_reg;

    // Result register
    logic                  out_valid_reg;
    lrukv_flags_t          out_flags_reg;
    logic [VALUE_BITS-1:0] out_rval_reg;
    logic [KEY_BITS-1:0]   out_evkey_reg;
    logic [OCC_BITS-1:0]   out_occ_reg;

    lrukv_cmd_t            cmd;
    lrukv_flags_t          res_flags;
    logic [VALUE_BITS-1:0] res_rval;
    logic [KEY_BITS-1:0]   res_evkey;
    logic [OCC_BITS-1:0]   res_occ;
    logic                  advance;
    logic                  s_fire;

    lrukv_cfg u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .capacity_limit (capacity_limit)
    );

    // Move the held request into the result register when it is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // Capture an incoming transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_type_reg <= s_tuser;
            in_key_reg  <= s_tdata[KEY_BITS-1:0];
            in_wval_reg <= s_tdata[KEY_BITS +: VALUE_BITS];
            in_dval_reg <= s_tdata[KEY_BITS + VALUE_BITS +: VALUE_BITS];
        end
    end

    assign cmd.fire     = advance;
    assign cmd.req_type = in_type_reg;

    lrukv_table #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_table (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .capacity_limit (capacity_limit),
        .lookup_key     (in_key_reg),
        .write_value    (in_wval_reg),
        .default_value  (in_dval_reg),
        .flags          (res_flags),
        .read_value     (res_rval),
        .evicted_key    (res_evkey),
        .occupancy      (res_occ)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_flags_reg <= res_flags;
            out_rval_reg  <= res_rval;
            out_evkey_reg <= res_evkey;
            out_occ_reg   <= res_occ;
        end
    end

    // Padding above the packed fields of m_tdata is zero
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_flags_reg.evicted, out_flags_reg.hit};
    assign m_tdata  = M_DATA_BITS'({out_occ_reg, out_evkey_reg, out_rval_reg});

endmodule

// File: src/lrukv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache result checker
// Port-level assertions on the result stream, bound to the cache top level.
// ----------------------------------------------------------------------------
module lrukv_checker
    import lrukv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int M_DATA_BITS = 72
)(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_DATA_BITS-1:0] m_tdata,
    input logic [1:0]             m_tuser
);

    logic [OCC_BITS-1:0] occ;
    logic [KEY_BITS-1:0] evkey;
    logic                hit;
    logic                evicted;

    assign occ     = m_tdata[VALUE_BITS + KEY_BITS +: OCC_BITS];
    assign evkey   = m_tdata[VALUE_BITS +: KEY_BITS];
    assign hit     = m_tuser[0];
    assign evicted = m_tuser[1];

    // No result is shown in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // An eviction only comes from a put of an absent key
    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && evicted |-> !hit)
        else $error("eviction reported with hit");

    // Evicted key reads zero without an eviction
    a_evkey_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !evicted |-> evkey == '0)
        else $error("evicted key nonzero without eviction");

    // Occupancy never exceeds the table size
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ENTRIES >= 32) || (32'(occ) <= ENTRIES))
        else $error("occupancy above table size");

endmodule

bind lru_key_value_cache lrukv_checker #(
    .ENTRIES     (ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS),
    .M_DATA_BITS (M_DATA_BITS)
) u_lrukv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Streams get, put, remove and clear requests into the cache and checks every
// result field against a cycle-free predictor of the LRU table. Capacity is
// reprogrammed over APB between phases (including zero and values above the
// table size). Both stream sides idle at random, and the result side holds
// off for long stretches so that the request path fills and stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import lrukv_pkg::*;

    localparam int SLOTS          = 16;
    localparam int KEY_POOL_SIZE  = 24;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] lookup_key;
        logic [31:0] write_value;
        logic [31:0] default_value;
    } cache_req_t;

    typedef struct packed {
        logic                hit;
        logic [31:0]         read_value;
        logic                evicted;
        logic [31:0]         evicted_key;
        logic [OCC_BITS-1:0] occupancy;
    } cache_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_BITS-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // lookup_key, write_value, default_value
    logic [95:0]           s_tdata  = '0;
    // req_type
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // read_value, evicted_key, occupancy
    logic [71:0]           m_tdata;
    // hit, evicted
    logic [1:0]            m_tuser;

    lru_key_value_cache dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predicted table contents
    logic [31:0]  slot_key [SLOTS];
    logic [31:0]  slot_val [SLOTS];
    bit           slot_live [SLOTS];
    int unsigned  slot_age [SLOTS];
    int unsigned  live_count       = 0;
    int unsigned  capacity_setting = 32'(CAP_RESET);

    cache_req_t    pending_reqs[$];
    cache_result_t expected_results[$];
    cache_req_t    offered_req;
    logic [31:0]   key_pool [KEY_POOL_SIZE];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int          hold_off_left  = 0;
    int          idle_cycles    = 0;
    int          mismatches     = 0;
    int          results_seen   = 0;
    int          req_tally [4]  = '{0, 0, 0, 0};
    int          hit_tally      = 0;
    int          evict_tally    = 0;
    int          capacity_writes = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Make slot s most recent; entries more recent than it age by one
    function automatic void promote_slot(int s);
        int unsigned r;
        r = slot_age[s];
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_age[i] < r)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    // Invalidate slot s; entries older than it move up by one
    function automatic void retire_slot(int s);
        int unsigned r;
        r = slot_age[s];
        slot_live[s] = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_age[i] > r)
                slot_age[i]--;
        if (live_count > 0)
            live_count--;
    endfunction

    // Apply one request to the predicted table and return its result
    function automatic cache_result_t resolve_request(cache_req_t rq);
        cache_result_t res;
        int            found;
        int            victim;
        int            free_slot;
        int unsigned   limit;
        int unsigned   oldest;
        res             = '0;
        res.read_value  = rq.default_value;
        limit = (capacity_setting == 0) ? 1 :
                (capacity_setting > SLOTS) ? SLOTS : capacity_setting;
        if (rq.req_type == REQ_CLEAR) begin
            foreach (slot_live[i])
                slot_live[i] = 1'b0;
            live_count = 0;
        end else begin
            found = -1;
            for (int i = 0; i < SLOTS; i++)
                if (found < 0 && slot_live[i] && slot_key[i] == rq.lookup_key)
                    found = i;
            res.hit = (found >= 0);
            case (rq.req_type)
                REQ_GET: begin
                    if (found >= 0) begin
                        res.read_value = slot_val[found];
                        promote_slot(found);
                    end
                end
                REQ_REMOVE: begin
                    if (found >= 0)
                        retire_slot(found);
                end
                REQ_PUT: begin
                    if (found >= 0) begin
                        slot_val[found] = rq.write_value;
                        promote_slot(found);
                    end else begin
                        // Evict at most one least recent entry
                        if (live_count >= limit) begin
                            victim = -1;
                            oldest = 0;
                            for (int i = 0; i < SLOTS; i++)
                                if (slot_live[i] && (victim < 0 || slot_age[i] > oldest)) begin
                                    victim = i;
                                    oldest = slot_age[i];
                                end
                            if (victim >= 0) begin
                                res.evicted     = 1'b1;
                                res.evicted_key = slot_key[victim];
                                retire_slot(victim);
                            end
                        end
                        free_slot = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (free_slot < 0 && !slot_live[i])
                                free_slot = i;
                        if (free_slot >= 0) begin
                            for (int i = 0; i < SLOTS; i++)
                                if (slot_live[i])
                                    slot_age[i]++;
                            slot_key[free_slot]  = rq.lookup_key;
                            slot_val[free_slot]  = rq.write_value;
                            slot_live[free_slot] = 1'b1;
                            slot_age[free_slot]  = 0;
                            live_count++;
                        end
                    end
                end
            endcase
        end
        res.occupancy = OCC_BITS'(live_count);
        return res;
    endfunction

    function automatic void queue_request(logic [1:0] kind, logic [31:0] key,
                                          logic [31:0] wval, logic [31:0] dval);
        cache_req_t rq;
        rq.req_type      = kind;
        rq.lookup_key    = key;
        rq.write_value   = wval;
        rq.default_value = dval;
        pending_reqs.push_back(rq);
    endfunction

    // Mostly keys from a small pool so that hits and evictions are common
    function automatic void queue_random(int count);
        int unsigned pick;
        logic [1:0]  kind;
        logic [31:0] key;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                kind = REQ_GET;
            else if (pick < 76)
                kind = REQ_PUT;
            else if (pick < 97)
                kind = REQ_REMOVE;
            else
                kind = REQ_CLEAR;
            if ($urandom_range(9) < 8)
                key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
            else
                key = $urandom();
            queue_request(kind, key, $urandom(), $urandom());
        end
    endfunction

    // Wait at the falling edge until every request has been answered
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // APB write of the capacity register while the cache is idle
    task automatic apply_capacity(logic [CAP_BITS-1:0] value);
        wait_drained();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'({REG_CAPACITY, 2'b00});
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity_setting = 32'(value);
        capacity_writes++;
        @(negedge aclk);
    endtask

    // Request driver: hold each transaction until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(resolve_request(offered_req));
                req_tally[offered_req.req_type]++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered_req.default_value, offered_req.write_value,
                                 offered_req.lookup_key};
                    s_tuser  <= offered_req.req_type;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transaction with the oldest prediction
    always @(posedge aclk) begin
        cache_result_t got;
        cache_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.read_value  = m_tdata[31:0];
                got.evicted_key = m_tdata[63:32];
                got.occupancy   = m_tdata[64 +: OCC_BITS];
                got.hit         = m_tuser[0];
                got.evicted     = m_tuser[1];
                if (expected_results.size() == 0) begin
                    $error("result %0d arrived with no request outstanding", results_seen);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        mismatches++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %08h, got %08h",
                               want.read_value, got.read_value);
                        mismatches++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                        mismatches++;
                    end
                    if (got.evicted_key !== want.evicted_key) begin
                        $error("evicted_key: expected %08h, got %08h",
                               want.evicted_key, got.evicted_key);
                        mismatches++;
                    end
                    if (got.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, got.occupancy);
                        mismatches++;
                    end
                    hit_tally   += 32'(want.hit);
                    evict_tally += 32'(want.evicted);
                end
                results_seen++;
                // Hold off long enough for the request path to back up
                if (results_seen == 350 || results_seen == 470)
                    hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Stimulus and phase sequencing
    initial begin
        foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 73;

        // Capacity two: miss, fill, hit, eviction, update, removes, clear
        apply_capacity(5'd2);
        queue_request(REQ_GET,    32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(REQ_PUT,    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_request(REQ_PUT,    32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(REQ_GET,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_request(REQ_PUT,    32'h0000_0005, 32'h1234_5678, 32'h0000_0000);
        queue_request(REQ_PUT,    32'h0000_0000, 32'hA5A5_A5A5, 32'h0000_0000);
        queue_request(REQ_REMOVE, 32'h0000_1234, 32'h0000_0000, 32'h0000_0000);
        queue_request(REQ_REMOVE, 32'h0000_0005, 32'h0000_0000, 32'h0000_0000);
        queue_request(REQ_GET,    32'h0000_0005, 32'h0000_0000, 32'h5A5A_5A5A);
        queue_request(REQ_CLEAR,  32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(REQ_GET,    32'h0000_0000, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
        queue_request(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

        // Capacity zero behaves as one
        apply_capacity(5'd0);
        queue_request(REQ_PUT, 32'h0000_0007, 32'hDEAD_BEEF, 32'h0000_0000);
        queue_request(REQ_PUT, 32'h0000_0008, 32'hCAFE_F00D, 32'h0000_0000);
        queue_request(REQ_GET, 32'h0000_0008, 32'h0000_0000, 32'h0000_0000);
        queue_request(REQ_PUT, 32'h0000_0008, 32'h0000_0001, 32'h0000_0000);
        queue_request(REQ_GET, 32'h0000_0007, 32'h0000_0000, 32'h8000_0000);

        // Capacity above the table size: fill the whole table and overflow
        apply_capacity(5'd31);
        queue_random(150);

        // Lower capacity below the current occupancy, sender idles more
        apply_capacity(5'd5);
        send_idle_pct = 73;
        recv_idle_pct = 17;
        queue_random(130);

        // No idling from here on; long receiver stalls occur in this stretch
        apply_capacity(5'd16);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(150);

        apply_capacity(5'd1);
        queue_random(60);

        apply_capacity(5'd9);
        queue_random(60);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            mismatches++;
        end

        $display("Checked %0d results: %0d gets, %0d puts, %0d removes, %0d clears",
                 results_seen, req_tally[REQ_GET], req_tally[REQ_PUT],
                 req_tally[REQ_REMOVE], req_tally[REQ_CLEAR]);
        $display("Hits %0d, evictions %0d, capacity settings %0d, mismatches %0d",
                 hit_tally, evict_tally, capacity_writes, mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
